// File: sv/spq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the sorted priority queue: operation and status
// codes, the stored entry layout and the sequencer states.
// ----------------------------------------------------------------------------
package spq_pkg;

    // Operation codes carried on mode
    localparam logic [1:0] MODE_ENQUEUE = 2'd0;
    localparam logic [1:0] MODE_DEQUEUE = 2'd1;
    localparam logic [1:0] MODE_PEEK    = 2'd2;
    localparam logic [1:0] MODE_NOP     = 2'd3;

    // Status codes returned with each result
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_UNDERFLOW = 2'd1;
    localparam logic [1:0] STATUS_FULL      = 2'd2;

    // Head value reported by a peek on an empty queue
    localparam logic [31:0] PEEK_EMPTY_VALUE = 32'hFFFF_FFFF;

    // One stored entry
    typedef struct packed {
        logic [31:0] priority_bits;
        logic [31:0] value;
    } spq_entry_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HEAD,
        ST_SCAN,
        ST_PLACE
    } spq_state_t;

endpackage

// File: sv/sorted_priority_queue_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_core
// Bounded priority queue kept in descending priority order in one entry
// store; enqueue, dequeue head and peek head, with a saturating insert cost.
//
//   Channel   Handshake             Payload
//   command   start / busy          mode, item_value, item_priority
//   result    done (1-cycle strobe) head_value, status, occupancy,
//                                   is_empty_flag, total_cost
//
// Dequeue, peek, the unused mode, refused enqueue, head insert and insert
// into a one-entry queue raise done from the head fetch state. Any other
// enqueue walks back from the tail one entry a cycle through the single
// read port and single write port of the store, then raises done. A new
// command is taken in the cycle done is shown. Reset clears count, cost and
// the head pointer; the store itself is not cleared.
// ----------------------------------------------------------------------------
module sorted_priority_queue_core
    import spq_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     mode,
    input  logic signed [31:0]             item_value,
    input  logic signed [31:0]             item_priority,
    output logic                           done,
    output logic signed [31:0]             head_value,
    output logic [1:0]                     status,
    output logic [$clog2(CAPACITY+1)-1:0]  occupancy,
    output logic                           is_empty_flag,
    output logic [31:0]                    total_cost
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    spq_entry_t    mem_wdata;
    spq_entry_t    mem_rdata;
    logic [31:0]   head_value_bits;

    // Sequencer
    spq_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .mode          (mode),
        .item_value    (item_value),
        .item_priority (item_priority),
        .busy          (busy),
        .done          (done),
        .head_value    (head_value_bits),
        .status        (status),
        .occupancy     (occupancy),
        .is_empty_flag (is_empty_flag),
        .total_cost    (total_cost),
        .mem_we        (mem_we),
        .mem_waddr     (mem_waddr),
        .mem_wdata     (mem_wdata),
        .mem_raddr     (mem_raddr),
        .mem_rdata     (mem_rdata)
    );

    // Entry store
    spq_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign head_value = $signed(head_value_bits);

endmodule

// File: sv/spq_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_mem
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module spq_mem
    import spq_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  spq_entry_t       wdata,
    input  logic [AW-1:0]    raddr,
    output spq_entry_t       rdata
);

    spq_entry_t mem [DEPTH];

    // Write and read, read data valid in the cycle after the address
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: sv/spq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_ctrl
// Operation sequencer. Keeps the queue as a ring in the entry store with a
// head pointer; an insert below the head walks back from the tail, moving
// each entry of lower or equal priority up one slot, then fills the gap.
// ----------------------------------------------------------------------------
module spq_ctrl
    import spq_pkg::*;
#(
    parameter int CAPACITY = 64,
    parameter int AW       = 6,
    parameter int CW       = 7
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [1:0]       mode,
    input  logic [31:0]      item_value,
    input  logic [31:0]      item_priority,
    output logic             busy,
    output logic             done,
    output logic [31:0]      head_value,
    output logic [1:0]       status,
    output logic [CW-1:0]    occupancy,
    output logic             is_empty_flag,
    output logic [31:0]      total_cost,
    output logic             mem_we,
    output logic [AW-1:0]    mem_waddr,
    output spq_entry_t       mem_wdata,
    output logic [AW-1:0]    mem_raddr,
    input  spq_entry_t       mem_rdata
);

    localparam int SUM_W = AW + 1;
    localparam logic [AW-1:0] ONE_IDX  = AW'(1);
    localparam logic [AW-1:0] LAST_IDX = AW'(CAPACITY - 1);

    // Map a position in the queue to a slot of the ring
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                              input logic [AW-1:0] ofs);
        logic [SUM_W-1:0] sum;
        sum = {1'b0, base} + {1'b0, ofs};
        if (sum >= SUM_W'(CAPACITY))
        begin
            sum = sum - SUM_W'(CAPACITY);
        end
        return sum[AW-1:0];
    endfunction

    spq_state_t state_reg, state_next;

    logic [1:0]    mode_reg, mode_next;
    logic [31:0]   value_reg, value_next;
    logic [31:0]   prio_reg, prio_next;
    logic [AW-1:0] head_ptr_reg, head_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic [31:0]   cost_reg, cost_next;
    logic [AW-1:0] scan_reg, scan_next;
    logic          done_reg, done_next;
    logic [31:0]   head_value_reg, head_value_next;
    logic [1:0]    status_reg, status_next;

    logic [AW-1:0] rd_pos;
    logic [AW-1:0] head_dec;
    logic [AW-1:0] count_low;
    logic          count_zero;
    logic          count_full;
    logic          count_one;
    logic          beats_head;
    logic          scan_move;
    logic          scan_last;
    logic [AW-1:0] cost_inc;
    logic [32:0]   cost_sum;
    logic [31:0]   cost_sat;
    spq_entry_t    new_entry;

    // Derived flags
    assign count_low  = count_reg[AW-1:0];
    assign count_zero = (count_reg == '0);
    assign count_full = (count_reg == CW'(CAPACITY));
    assign count_one  = (count_reg == CW'(1));
    assign beats_head = $signed(prio_reg) > $signed(mem_rdata.priority_bits);
    assign scan_move  = $signed(mem_rdata.priority_bits) <= $signed(prio_reg);
    assign scan_last  = (scan_reg == ONE_IDX);
    assign head_dec   = (head_ptr_reg == '0) ? LAST_IDX : head_ptr_reg - ONE_IDX;
    assign new_entry  = '{priority_bits: prio_reg, value: value_reg};

    // Saturating cost update: landing position, or one for the head
    assign cost_inc = (state_reg == ST_SCAN) ? scan_reg + ONE_IDX : ONE_IDX;
    assign cost_sum = {1'b0, cost_reg} + 33'(cost_inc);
    assign cost_sat = cost_sum[32] ? 32'hFFFF_FFFF : cost_sum[31:0];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_HEAD;
                end
            end
            ST_HEAD:
            begin
                if (mode_reg == MODE_ENQUEUE && !count_full && !count_zero &&
                    !beats_head && !count_one)
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (scan_move)
                begin
                    state_next = scan_last ? ST_PLACE : ST_SCAN;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_PLACE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and memory controls
    always_comb
    begin
        mode_next       = mode_reg;
        value_next      = value_reg;
        prio_next       = prio_reg;
        head_ptr_next   = head_ptr_reg;
        count_next      = count_reg;
        cost_next       = cost_reg;
        scan_next       = scan_reg;
        done_next       = 1'b0;
        head_value_next = head_value_reg;
        status_next     = status_reg;
        mem_we          = 1'b0;
        mem_waddr       = head_ptr_reg;
        mem_wdata       = new_entry;
        rd_pos          = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                // Capture the command, fetch the head
                if (start)
                begin
                    mode_next  = mode;
                    value_next = item_value;
                    prio_next  = item_priority;
                end
            end
            ST_HEAD:
            begin
                unique case (mode_reg)
                    MODE_ENQUEUE:
                    begin
                        head_value_next = '0;
                        status_next     = STATUS_OK;
                        if (count_full)
                        begin
                            status_next = STATUS_FULL;
                            done_next   = 1'b1;
                        end
                        else if (count_zero || beats_head)
                        begin
                            // New head: grow the ring backward
                            mem_we        = 1'b1;
                            mem_waddr     = head_dec;
                            head_ptr_next = head_dec;
                            count_next    = count_reg + CW'(1);
                            cost_next     = cost_sat;
                            done_next     = 1'b1;
                        end
                        else if (count_one)
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = slot_of(head_ptr_reg, ONE_IDX);
                            count_next = count_reg + CW'(1);
                            cost_next  = cost_sat;
                            done_next  = 1'b1;
                        end
                        else
                        begin
                            // Start the walk at the tail
                            scan_next = count_low - ONE_IDX;
                            rd_pos    = count_low - ONE_IDX;
                        end
                    end
                    MODE_DEQUEUE:
                    begin
                        done_next = 1'b1;
                        if (count_zero)
                        begin
                            head_value_next = '0;
                            status_next     = STATUS_UNDERFLOW;
                        end
                        else
                        begin
                            head_value_next = mem_rdata.value;
                            status_next     = STATUS_OK;
                            head_ptr_next   = slot_of(head_ptr_reg, ONE_IDX);
                            count_next      = count_reg - CW'(1);
                        end
                    end
                    MODE_PEEK:
                    begin
                        done_next = 1'b1;
                        if (count_zero)
                        begin
                            head_value_next = PEEK_EMPTY_VALUE;
                            status_next     = STATUS_UNDERFLOW;
                        end
                        else
                        begin
                            head_value_next = mem_rdata.value;
                            status_next     = STATUS_OK;
                        end
                    end
                    MODE_NOP:
                    begin
                        done_next       = 1'b1;
                        head_value_next = '0;
                        status_next     = STATUS_OK;
                    end
                endcase
            end
            ST_SCAN:
            begin
                mem_we    = 1'b1;
                mem_waddr = slot_of(head_ptr_reg, scan_reg + ONE_IDX);
                if (scan_move)
                begin
                    // Move this entry up one slot, fetch the one before it
                    mem_wdata = mem_rdata;
                    if (!scan_last)
                    begin
                        scan_next = scan_reg - ONE_IDX;
                        rd_pos    = scan_reg - ONE_IDX;
                    end
                end
                else
                begin
                    // Found a higher priority: place the new entry behind it
                    count_next = count_reg + CW'(1);
                    cost_next  = cost_sat;
                    done_next  = 1'b1;
                end
            end
            ST_PLACE:
            begin
                mem_we     = 1'b1;
                mem_waddr  = slot_of(head_ptr_reg, ONE_IDX);
                count_next = count_reg + CW'(1);
                cost_next  = cost_sat;
                done_next  = 1'b1;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    assign mem_raddr = slot_of(head_ptr_reg, rd_pos);

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            head_ptr_reg <= '0;
            count_reg    <= '0;
            cost_reg     <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            head_ptr_reg <= head_ptr_next;
            count_reg    <= count_next;
            cost_reg     <= cost_next;
            done_reg     <= done_next;
        end
    end

    // Payload holding registers
    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        value_reg      <= value_next;
        prio_reg       <= prio_next;
        scan_reg       <= scan_next;
        head_value_reg <= head_value_next;
        status_reg     <= status_next;
    end

    assign busy          = (state_reg != ST_IDLE);
    assign done          = done_reg;
    assign head_value    = head_value_reg;
    assign status        = status_reg;
    assign occupancy     = count_reg;
    assign is_empty_flag = count_zero;
    assign total_cost    = cost_reg;

endmodule

// File: sv/spq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks on the queue: command and result timing, status
// consistency and cost behavior.
// ----------------------------------------------------------------------------
module spq_checker
    import spq_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           busy,
    input  logic                           done,
    input  logic [1:0]                     status,
    input  logic [$clog2(CAPACITY+1)-1:0]  occupancy,
    input  logic                           is_empty_flag,
    input  logic [31:0]                    total_cost
);

    // A transfer always occupies the block in the next cycle
    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy low right after a command transfer");

    // A result is shown only once the block is free again
    a_done_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    // A refused enqueue reports a full queue
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == STATUS_FULL |-> occupancy == ($clog2(CAPACITY+1))'(CAPACITY))
        else $error("full status with spare room");

    // Underflow only on an empty queue
    a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == STATUS_UNDERFLOW |-> is_empty_flag)
        else $error("underflow reported on a non-empty queue");

    // Cost never decreases
    a_cost_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> total_cost >= $past(total_cost))
        else $error("total cost decreased");

endmodule

bind sorted_priority_queue_core spq_checker #(
    .CAPACITY (CAPACITY)
) u_spq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .status        (status),
    .occupancy     (occupancy),
    .is_empty_flag (is_empty_flag),
    .total_cost    (total_cost)
);

// File: bench/tb_sorted_priority_queue_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_priority_queue_core
// Self-checking bench for the sorted priority queue. A short stimulus table
// covers the empty queue, field extremes, equal priorities and the unused
// mode. Random phases then fill the queue past full, drain it past empty,
// and mix all modes. Every result strobe is checked against a behavioral
// queue model updated on each command transfer, or a row's typed result.
// ----------------------------------------------------------------------------
module tb_sorted_priority_queue_core
    import spq_pkg::*;
();

    localparam int CAPACITY     = 64;
    localparam int OCC_W        = $clog2(CAPACITY + 1);
    localparam int RANDOM_ITEMS = 1800;
    localparam int MAX_REPORTS  = 10;
    // enqueue walks at most one entry a cycle, plus fixed overhead
    localparam int SETTLE_CYCLES = CAPACITY + 16;

    typedef struct packed {
        logic signed [31:0] head;
        logic [1:0]         status;
        logic [OCC_W-1:0]   occ;
        logic               empty;
        logic [31:0]        cost;
    } result_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] value;
        logic [31:0] prio;
        logic        typed;
        result_t     res;
    } stim_row_t;

    localparam result_t NO_EXPECT = '0;
    localparam int      N_ROWS    = 25;

    // Directed rows; typed expectations only where they are obvious
    localparam stim_row_t DIRECTED [0:N_ROWS-1] = '{
        '{MODE_DEQUEUE, 32'h0000_0000, 32'h0000_0000, 1'b1,
          '{32'h0000_0000, STATUS_UNDERFLOW, 7'd0, 1'b1, 32'd0}},
        '{MODE_PEEK,    32'h0000_0000, 32'h0000_0000, 1'b1,
          '{PEEK_EMPTY_VALUE, STATUS_UNDERFLOW, 7'd0, 1'b1, 32'd0}},
        '{MODE_NOP,     32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
          '{32'h0000_0000, STATUS_OK, 7'd0, 1'b1, 32'd0}},
        '{MODE_ENQUEUE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1,
          '{32'h0000_0000, STATUS_OK, 7'd1, 1'b0, 32'd1}},
        '{MODE_PEEK,    32'h0000_0000, 32'h0000_0000, 1'b1,
          '{32'h7FFF_FFFF, STATUS_OK, 7'd1, 1'b0, 32'd1}},
        // same priority as the head: lands behind it
        '{MODE_ENQUEUE, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, NO_EXPECT},
        '{MODE_ENQUEUE, 32'h0000_0000, 32'h8000_0000, 1'b0, NO_EXPECT},
        '{MODE_ENQUEUE, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, NO_EXPECT},
        // equal priority deeper in: lands before the older equal entry
        '{MODE_ENQUEUE, 32'h0000_0001, 32'h0000_0000, 1'b0, NO_EXPECT},
        '{MODE_ENQUEUE, 32'h0000_0002, 32'h8000_0000, 1'b0, NO_EXPECT},
        '{MODE_NOP,     32'h1234_5678, 32'h0000_0000, 1'b0, NO_EXPECT},
        '{MODE_PEEK,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, NO_EXPECT},
        '{MODE_DEQUEUE, 32'h0000_0000, 32'h0000_0000, 1'b0, NO_EXPECT},
        '{MODE_DEQUEUE, 32'h0000_0000, 32'h0000_0000, 1'b0, NO_EXPECT},
        '{MODE_DEQUEUE, 32'h0000_0000, 32'h0000_0000, 1'b0, NO_EXPECT},
        '{MODE_DEQUEUE, 32'h0000_0000, 32'h0000_0000, 1'b0, NO_EXPECT},
        '{MODE_DEQUEUE, 32'h0000_0000, 32'h0000_0000, 1'b0, NO_EXPECT},
        '{MODE_DEQUEUE, 32'h0000_0000, 32'h0000_0000, 1'b0, NO_EXPECT},
        '{MODE_DEQUEUE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, NO_EXPECT},
        '{MODE_ENQUEUE, 32'h0000_0003, 32'hFFFF_FFFF, 1'b0, NO_EXPECT},
        // strictly above the head: head insert
        '{MODE_ENQUEUE, 32'h0000_0004, 32'h7FFF_FFFF, 1'b0, NO_EXPECT},
        '{MODE_ENQUEUE, 32'h0000_0005, 32'h8000_0000, 1'b0, NO_EXPECT},
        '{MODE_PEEK,    32'h0000_0000, 32'h0000_0000, 1'b0, NO_EXPECT},
        '{MODE_DEQUEUE, 32'h0000_0000, 32'h0000_0000, 1'b0, NO_EXPECT},
        '{MODE_DEQUEUE, 32'h0000_0000, 32'h0000_0000, 1'b0, NO_EXPECT}
    };

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic [1:0]               mode;
    logic signed [31:0]       item_value;
    logic signed [31:0]       item_priority;
    logic                     done;
    logic signed [31:0]       head_value;
    logic [1:0]               status;
    logic [OCC_W-1:0]         occupancy;
    logic                     is_empty_flag;
    logic [31:0]              total_cost;

    // Typed expectation travelling with the command currently driven
    logic                     row_typed;
    result_t                  row_expect;

    // Queue model state
    logic [31:0]              model_val  [CAPACITY];
    logic signed [31:0]       model_prio [CAPACITY];
    int                       model_count = 0;
    logic [31:0]              model_cost  = '0;

    result_t                  pending_results [$];
    int                       mismatches = 0;
    int                       sent_count = 0;
    int                       sent_occupancy = 0;
    int                       no_gap_run = 0;

    sorted_priority_queue_core #(
        .CAPACITY (CAPACITY)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .mode          (mode),
        .item_value    (item_value),
        .item_priority (item_priority),
        .done          (done),
        .head_value    (head_value),
        .status        (status),
        .occupancy     (occupancy),
        .is_empty_flag (is_empty_flag),
        .total_cost    (total_cost)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Timeout
    initial
    begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // Apply one command to the queue model and return the expected result
    function automatic result_t apply_queue_op(input logic [1:0] op,
                                               input logic [31:0] val,
                                               input logic signed [31:0] pri);
        result_t r;
        int      pos;
        int      step_cost;
        r = '0;
        case (op)
            MODE_ENQUEUE:
            begin
                if (model_count >= CAPACITY)
                begin
                    r.status = STATUS_FULL;
                end
                else
                begin
                    // find the landing slot
                    if (model_count == 0 || pri > model_prio[0])
                    begin
                        pos = 0;
                        step_cost = 1;
                    end
                    else
                    begin
                        pos = 1;
                        while (pos < model_count && model_prio[pos] > pri)
                            pos++;
                        step_cost = pos;
                    end
                    // saturate the cost counter
                    if (model_cost > 32'hFFFF_FFFF - step_cost)
                        model_cost = 32'hFFFF_FFFF;
                    else
                        model_cost = model_cost + step_cost;
                    // shift the tail down and place the entry
                    for (int s = model_count; s > pos; s--)
                    begin
                        model_val[s]  = model_val[s-1];
                        model_prio[s] = model_prio[s-1];
                    end
                    model_val[pos]  = val;
                    model_prio[pos] = pri;
                    model_count++;
                end
            end
            MODE_DEQUEUE:
            begin
                if (model_count == 0)
                begin
                    r.status = STATUS_UNDERFLOW;
                end
                else
                begin
                    r.head = model_val[0];
                    for (int s = 1; s < model_count; s++)
                    begin
                        model_val[s-1]  = model_val[s];
                        model_prio[s-1] = model_prio[s];
                    end
                    model_count--;
                end
            end
            MODE_PEEK:
            begin
                if (model_count == 0)
                begin
                    r.status = STATUS_UNDERFLOW;
                    r.head   = PEEK_EMPTY_VALUE;
                end
                else
                begin
                    r.head = model_val[0];
                end
            end
            default:
            begin
                // unused mode changes nothing
            end
        endcase
        r.occ   = model_count[OCC_W-1:0];
        r.empty = (model_count == 0);
        r.cost  = model_cost;
        return r;
    endfunction

    // Check each result strobe, then record the command taken at this edge
    always @(posedge clk)
    begin : check_results
        result_t want;
        result_t got;
        if (rst_n)
        begin
            if (done)
            begin
                got = '{head_value, status, occupancy, is_empty_flag, total_cost};
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: result with nothing expected: head %h status %0d",
                                 $realtime, head_value, status);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.head !== want.head || got.status !== want.status ||
                        got.occ !== want.occ || got.empty !== want.empty ||
                        got.cost !== want.cost)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                        begin
                            $write("%0t: exp head %h st %0d occ %0d emp %0d cost %0d",
                                   $realtime, want.head, want.status, want.occ,
                                   want.empty, want.cost);
                            $display(" / got head %h st %0d occ %0d emp %0d cost %0d",
                                     got.head, got.status, got.occ, got.empty,
                                     got.cost);
                        end
                    end
                end
            end
            if (start && !busy)
            begin
                want = apply_queue_op(mode, item_value, item_priority);
                if (row_typed)
                    want = row_expect;
                pending_results.push_back(want);
            end
        end
    end

    // Gap length before the next command: mostly short, a few long
    function automatic int pick_gap();
        int r;
        if (no_gap_run > 0)
        begin
            no_gap_run--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            no_gap_run = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Priorities: small set for ties, extremes, or anything
    function automatic logic [31:0] pick_priority();
        int r;
        r = $urandom_range(0, 7);
        if (r < 3)
            return $urandom_range(0, 3);
        if (r == 3)
        begin
            case ($urandom_range(0, 3))
                0: return 32'h7FFF_FFFF;
                1: return 32'h8000_0000;
                2: return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        return $urandom;
    endfunction

    // Drive one command and hold it until the transfer
    task automatic send_cmd(input logic [1:0] op, input logic [31:0] val,
                            input logic [31:0] pri, input logic typed,
                            input result_t res);
        start         <= 1'b1;
        mode          <= op;
        item_value    <= val;
        item_priority <= pri;
        row_typed     <= typed;
        row_expect    <= res;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        // track occupancy on the sending side for phase decisions
        if (op == MODE_ENQUEUE && sent_occupancy < CAPACITY)
            sent_occupancy++;
        else if (op == MODE_DEQUEUE && sent_occupancy > 0)
            sent_occupancy--;
        sent_count++;
    endtask

    task automatic idle_random();
        int n;
        n = pick_gap();
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Hold off until every expected result has come
    task automatic wait_drained();
        start <= 1'b0;
        do
            @(negedge clk);
        while (pending_results.size() != 0);
        @(posedge clk);
    endtask

    task automatic send_random(input logic [1:0] op);
        send_cmd(op, $urandom, pick_priority(), 1'b0, NO_EXPECT);
        idle_random();
    endtask

    // Stimulus
    initial
    begin : stimulus
        int       r;
        int       n;
        logic [1:0] op;
        rst_n         = 1'b0;
        start         = 1'b0;
        mode          = MODE_NOP;
        item_value    = '0;
        item_priority = '0;
        row_typed     = 1'b0;
        row_expect    = NO_EXPECT;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // walk the directed table
        for (int i = 0; i < N_ROWS; i++)
        begin
            send_cmd(DIRECTED[i].op, DIRECTED[i].value, DIRECTED[i].prio,
                     DIRECTED[i].typed, DIRECTED[i].res);
            idle_random();
        end
        wait_drained();

        // random phases
        while (sent_count < N_ROWS + RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 3);
            if (r == 0)
            begin
                // fill to full, then push a few refused enqueues
                while (sent_occupancy < CAPACITY)
                    send_random(MODE_ENQUEUE);
                repeat ($urandom_range(1, 3)) send_random(MODE_ENQUEUE);
            end
            else if (r == 1)
            begin
                // drain to empty with some peeks, then underflow a few times
                while (sent_occupancy > 0)
                    send_random(($urandom_range(0, 3) == 0) ? MODE_PEEK : MODE_DEQUEUE);
                repeat ($urandom_range(1, 3))
                    send_random($urandom_range(0, 1) ? MODE_PEEK : MODE_DEQUEUE);
            end
            else
            begin
                // mixed traffic, unused mode included
                n = $urandom_range(20, 60);
                repeat (n)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 45)
                        op = MODE_ENQUEUE;
                    else if (r < 75)
                        op = MODE_DEQUEUE;
                    else if (r < 90)
                        op = MODE_PEEK;
                    else
                        op = MODE_NOP;
                    send_random(op);
                end
            end
            if ($urandom_range(0, 5) == 0)
                wait_drained();
        end

        // drain with a bound, then let the block settle
        start <= 1'b0;
        n = 0;
        while (pending_results.size() != 0 && n < 4 * SETTLE_CYCLES)
        begin
            @(negedge clk);
            n++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            mismatches++;
            $display("%0d expected results never arrived", pending_results.size());
        end

        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
